@@ rtl/core/fmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmc_pkg
// Types, constants and helper functions shared by the file magic classifier.
// ----------------------------------------------------------------------------
package fmc_pkg;

	localparam int HEAD_DEPTH = 20;
	localparam int TAR_OFFSET = 257;
	localparam int TAR_END    = 262;
	localparam int IN_W       = 8;
	localparam int OUT_W      = 24;

	typedef enum logic [3:0] {
		KIND_EMPTY  = 4'd0,
		KIND_ELF    = 4'd1,
		KIND_SCRIPT = 4'd2,
		KIND_PNG    = 4'd3,
		KIND_JPEG   = 4'd4,
		KIND_GIF    = 4'd5,
		KIND_GZIP   = 4'd6,
		KIND_ZIP    = 4'd7,
		KIND_PDF    = 4'd8,
		KIND_TAR    = 4'd9,
		KIND_BMP    = 4'd10,
		KIND_WAV    = 4'd11,
		KIND_TEXT   = 4'd12,
		KIND_DATA   = 4'd13
	} kind_t;

	typedef enum logic [1:0] {
		ELF_REL    = 2'd0,
		ELF_EXEC   = 2'd1,
		ELF_SHARED = 2'd2,
		ELF_OTHER  = 2'd3
	} elf_kind_t;

	localparam logic [15:0] ELF_MACHINE_ARM = 16'd40;

	// Running picture of the file gathered byte by byte.
	typedef struct packed {
		logic [HEAD_DEPTH-1:0][7:0] head;
		logic                       tar_match;
		logic                       text_clean;
		logic                       nl_found;
		logic [5:0]                 nl_pos;
	} scan_t;

	typedef struct packed {
		kind_t     file_kind;
		elf_kind_t elf_kind;
		logic      elf_arm;
		logic [5:0] script_len;
		logic [9:0] bytes_seen;
	} result_t;

	// A control byte that rules out plain text.
	function automatic logic is_forbidden(input logic [7:0] c);
		logic bad;
		bad = 1'b0;
		if (c == 8'h00 || c == 8'h7F) begin
			bad = 1'b1;
		end else if (c < 8'd32 && c != 8'd9 && c != 8'd10 && c != 8'd13 &&
				c != 8'd12 && c != 8'd27) begin
			bad = 1'b1;
		end
		return bad;
	endfunction

	// Expected character of the tar tag at a given position.
	function automatic logic [7:0] tar_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = "u";
			3'd1: ch = "s";
			3'd2: ch = "t";
			3'd3: ch = "a";
			3'd4: ch = "r";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/core/fmc_scan.sv @@
// ----------------------------------------------------------------------------
// fmc_scan
// Per-byte state: header bytes, tar tag, text test and shebang newline.
// ----------------------------------------------------------------------------
module fmc_scan
	import fmc_pkg::*;
#(
	parameter int MAX_HEADER   = 512,
	parameter int SCRIPT_LIMIT = 40,
	localparam int CW          = $clog2(MAX_HEADER + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_en,
	input  logic          clear,
	input  logic [7:0]    data,
	output scan_t         st,
	output logic [CW-1:0] count
);

	// Fresh-file picture: head zero, tar tag and text test still passing, no newline.
	localparam scan_t SCAN_INIT = {{(HEAD_DEPTH * 8){1'b0}}, 1'b1, 1'b1, 1'b0, 6'd0};

	scan_t         st_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			st_q    <= SCAN_INIT;
		end else if (clear) begin
			count_q <= '0;
			st_q    <= SCAN_INIT;
		end else if (byte_en && count_q < CW'(MAX_HEADER)) begin
			count_q <= count_q + 1'b1;
			if (count_q < CW'(HEAD_DEPTH)) begin
				st_q.head[count_q[4:0]] <= data;
			end
			if (count_q >= CW'(TAR_OFFSET) && count_q < CW'(TAR_END) &&
					data != tar_char(3'(count_q - CW'(TAR_OFFSET)))) begin
				st_q.tar_match <= 1'b0;
			end
			if (is_forbidden(data)) begin
				st_q.text_clean <= 1'b0;
			end
			// Only the first newline inside the interpreter window counts.
			if (!st_q.nl_found && count_q >= CW'(2) && count_q < CW'(SCRIPT_LIMIT) &&
					data == 8'd10) begin
				st_q.nl_found <= 1'b1;
				st_q.nl_pos   <= 6'(count_q);
			end
		end
	end

	assign st    = st_q;
	assign count = count_q;

endmodule

@@ rtl/core/fmc_decide.sv @@
// ----------------------------------------------------------------------------
// fmc_decide
// Priority classifier over the gathered header picture.
// ----------------------------------------------------------------------------
module fmc_decide
	import fmc_pkg::*;
#(
	parameter int MAX_HEADER   = 512,
	parameter int SCRIPT_LIMIT = 40,
	localparam int CW          = $clog2(MAX_HEADER + 1)
) (
	input  scan_t         st,
	input  logic [CW-1:0] count,
	output result_t       res
);

	logic [HEAD_DEPTH-1:0][7:0] b;
	logic [15:0] etype;
	logic [15:0] mach;
	logic [6:0]  send;
	logic [6:0]  sfin;

	assign b     = st.head;
	assign etype = {b[17], b[16]};
	assign mach  = {b[19], b[18]};

	// End of the interpreter text: file end, window end or first newline.
	always_comb begin
		send = (count < CW'(SCRIPT_LIMIT)) ? 7'(count) : 7'(SCRIPT_LIMIT);
		sfin = send;
		if (st.nl_found && {1'b0, st.nl_pos} < send) begin
			sfin = {1'b0, st.nl_pos};
		end
	end

	always_comb begin
		res            = '0;
		res.file_kind  = KIND_DATA;
		res.bytes_seen = 10'(count);
		if (count == '0) begin
			res.file_kind = KIND_EMPTY;
		end else if (count >= CW'(4) && b[0] == 8'h7F && b[1] == "E" && b[2] == "L" &&
				b[3] == "F") begin
			res.file_kind = KIND_ELF;
			res.elf_kind  = (etype == 16'd1) ? ELF_REL :
					(etype == 16'd2) ? ELF_EXEC :
					(etype == 16'd3) ? ELF_SHARED : ELF_OTHER;
			res.elf_arm   = (mach == ELF_MACHINE_ARM);
		end else if (count >= CW'(2) && b[0] == "#" && b[1] == "!") begin
			res.file_kind  = KIND_SCRIPT;
			res.script_len = (sfin > 7'd2) ? 6'(sfin - 7'd2) : 6'd0;
		end else if (count >= CW'(8) && b[0] == 8'h89 && b[1] == "P" && b[2] == "N" &&
				b[3] == "G" && b[4] == 8'd13 && b[5] == 8'd10 && b[6] == 8'h1A &&
				b[7] == 8'd10) begin
			res.file_kind = KIND_PNG;
		end else if (count >= CW'(3) && b[0] == 8'hFF && b[1] == 8'hD8 &&
				b[2] == 8'hFF) begin
			res.file_kind = KIND_JPEG;
		end else if (count >= CW'(4) && b[0] == "G" && b[1] == "I" && b[2] == "F" &&
				b[3] == "8") begin
			res.file_kind = KIND_GIF;
		end else if (count >= CW'(2) && b[0] == 8'h1F && b[1] == 8'h8B) begin
			res.file_kind = KIND_GZIP;
		end else if (count >= CW'(4) && b[0] == "P" && b[1] == "K" &&
				((b[2] == 8'd3 && b[3] == 8'd4) || (b[2] == 8'd5 && b[3] == 8'd6))) begin
			res.file_kind = KIND_ZIP;
		end else if (count >= CW'(5) && b[0] == "%" && b[1] == "P" && b[2] == "D" &&
				b[3] == "F" && b[4] == "-") begin
			res.file_kind = KIND_PDF;
		end else if (count >= CW'(TAR_END) && st.tar_match) begin
			res.file_kind = KIND_TAR;
		end else if (count >= CW'(2) && b[0] == "B" && b[1] == "M") begin
			res.file_kind = KIND_BMP;
		end else if (count >= CW'(12) && b[0] == "R" && b[1] == "I" && b[2] == "F" &&
				b[3] == "F" && b[8] == "W" && b[9] == "A" && b[10] == "V" &&
				b[11] == "E") begin
			res.file_kind = KIND_WAV;
		end else if (count >= CW'(3) && b[0] == 8'hEF && b[1] == 8'hBB &&
				b[2] == 8'hBF) begin
			res.file_kind = KIND_TEXT;
		end else if (st.text_clean) begin
			res.file_kind = KIND_TEXT;
		end
	end

endmodule

@@ rtl/core/file_magic_classifier.sv @@
// An end-of-file word waits in the input register, then the classifier loads the result
//   register with its result once that register is free.
// Throughput: one word per cycle on the input; each data byte moves through the input register.
// Only an end-of-file word meets a stalled result register and can hold the input back.
// Reset (arst_n low, asynchronous): clears all valid flags and the per-file state, so the
//   block starts at once on a fresh file; it also returns to that state after every result.
// ----------------------------------------------------------------------------
// file_magic_classifier
// Streams a file byte by byte and reports its type from the leading magic bytes.
// ----------------------------------------------------------------------------
module file_magic_classifier
	import fmc_pkg::*;
#(
	parameter int MAX_HEADER   = 512,
	parameter int SCRIPT_LIMIT = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	// Input words.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [7:0] data_byte
	input  logic             s_tlast,   // end_of_file
	// Result words.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [3:0] file_kind, [5:4] elf_kind, [6] elf_arm,
	                                    // [12:7] script_len, [22:13] bytes_seen, [23] zero
);

	localparam int CW = $clog2(MAX_HEADER + 1);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// Result register stage.
	logic    valid_s2;
	result_t res_s2;

	logic          out_free;
	logic          process;
	scan_t         st;
	logic [CW-1:0] count;
	result_t       res;

	// The result register can take a word when empty or being drained this cycle.
	assign out_free = !valid_s2 || m_tready;
	// A data byte always moves on; an end-of-file word waits for the result register.
	assign process  = valid_s1 && (!eof_s1 || out_free);
	assign s_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			eof_s1  <= s_tlast;
		end
	end

	fmc_scan #(
		.MAX_HEADER  (MAX_HEADER),
		.SCRIPT_LIMIT(SCRIPT_LIMIT)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_en(process && !eof_s1),
		.clear  (process && eof_s1),
		.data   (byte_s1),
		.st     (st),
		.count  (count)
	);

	fmc_decide #(
		.MAX_HEADER  (MAX_HEADER),
		.SCRIPT_LIMIT(SCRIPT_LIMIT)
	) u_decide (
		.st   (st),
		.count(count),
		.res  (res)
	);

	// The result register loads on the end-of-file word and drops once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (process && eof_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && eof_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.bytes_seen, res_s2.script_len, res_s2.elf_arm,
			res_s2.elf_kind, res_s2.file_kind};

`ifndef NO_ASSERTIONS
	a_eof_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(process && eof_s1) |=> valid_s2)
		else $error("end of file did not produce a result");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_HEADER))
		else $error("byte count passed the header limit");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.file_kind == KIND_EMPTY) |-> res_s2.bytes_seen == 10'd0)
		else $error("empty file reported with bytes");

	a_elf_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.file_kind != KIND_ELF) |->
			(res_s2.elf_kind == ELF_REL && !res_s2.elf_arm))
		else $error("ELF fields set for a non-ELF file");

	a_script_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.file_kind != KIND_SCRIPT) |-> res_s2.script_len == 6'd0)
		else $error("script length set for a non-script file");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(process && eof_s1) |=> (count == '0 && st.tar_match && st.text_clean))
		else $error("per-file state not cleared after a result");
`endif

endmodule

@@ test/tb_file_magic_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_file_magic_classifier
// Streams whole files into the classifier and checks every verdict against a
// predictor kept inside the bench, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_file_magic_classifier;
	import fmc_pkg::*;

	localparam int MAX_HEADER   = 512;
	localparam int SCRIPT_LIMIT = 40;
	localparam int CYCLE_LIMIT  = 400000;
	// Extra cycles run after the last verdict, which trails its end-of-file word through two registers.
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_WORDS  = 30;
	localparam logic [39:0] USTAR = "ustar";

	// Shapes of generated files; the plain shape carries only filler bytes.
	typedef enum int {
		SH_EMPTY, SH_ELF, SH_SCRIPT, SH_PNG, SH_JPEG, SH_GIF, SH_GZIP, SH_ZIP,
		SH_PDF, SH_TAR, SH_BMP, SH_WAV, SH_BOM, SH_PLAIN
	} shape_t;

	// Kinds of filler: any byte, printable only, text-safe bytes, printable with newlines.
	typedef enum int {FILL_ANY, FILL_PRINT, FILL_TEXT, FILL_LINE} fill_t;

	// Follows the classifier word by word and holds the verdicts still owed by it.
	class verdict_board;
		result_t     verdicts_due[$];
		int unsigned failures;
		int unsigned taken;
		logic [7:0]  head [HEAD_DEPTH];
		bit          tar_ok;
		bit          clean;
		bit          nl_seen;
		int unsigned nl_at;

		function new();
			failures = 0;
			start_file();
		endfunction

		function void start_file();
			taken = 0;
			foreach (head[k]) head[k] = 8'h00;
			tar_ok  = 1'b1;
			clean   = 1'b1;
			nl_seen = 1'b0;
			nl_at   = 0;
		endfunction

		// Takes one accepted input word; an end-of-file word yields a verdict.
		function void note_word(logic [7:0] c, logic eof);
			result_t     r;
			int unsigned stop;
			if (!eof) begin
				// Bytes beyond the header window change nothing at all.
				if (taken >= MAX_HEADER) return;
				if (taken < HEAD_DEPTH) head[taken] = c;
				if (taken >= TAR_OFFSET && taken < TAR_END &&
						c != USTAR[39 - 8 * (taken - TAR_OFFSET) -: 8]) tar_ok = 1'b0;
				// Tab, line feed, form feed, carriage return and escape are
				// the only control bytes that plain text may hold.
				if (c == 8'h7F || (c < 8'd32 && c != 8'd9 && c != 8'd10 &&
						c != 8'd12 && c != 8'd13 && c != 8'd27)) clean = 1'b0;
				if (!nl_seen && taken >= 2 && taken < SCRIPT_LIMIT && c == 8'h0A) begin
					nl_seen = 1'b1;
					nl_at   = taken;
				end
				taken++;
				return;
			end
			r.file_kind  = KIND_DATA;
			r.elf_kind   = ELF_REL;
			r.elf_arm    = 1'b0;
			r.script_len = 6'd0;
			r.bytes_seen = 10'(taken);
			if (taken == 0) begin
				r.file_kind = KIND_EMPTY;
			end else if (taken >= 4 && {head[0], head[1], head[2], head[3]} == 32'h7F454C46) begin
				// Type and machine fields past a short file read as zero.
				r.file_kind = KIND_ELF;
				case ({head[17], head[16]})
					16'd1: r.elf_kind = ELF_REL;
					16'd2: r.elf_kind = ELF_EXEC;
					16'd3: r.elf_kind = ELF_SHARED;
					default: r.elf_kind = ELF_OTHER;
				endcase
				r.elf_arm = ({head[19], head[18]} == ELF_MACHINE_ARM);
			end else if (taken >= 2 && {head[0], head[1]} == "#!") begin
				r.file_kind = KIND_SCRIPT;
				stop = (taken < SCRIPT_LIMIT) ? taken : SCRIPT_LIMIT;
				if (nl_seen && nl_at < stop) stop = nl_at;
				r.script_len = (stop > 2) ? 6'(stop - 2) : 6'd0;
			end else if (taken >= 8 && {head[0], head[1], head[2], head[3], head[4], head[5],
					head[6], head[7]} == 64'h89504E470D0A1A0A) begin
				r.file_kind = KIND_PNG;
			end else if (taken >= 3 && {head[0], head[1], head[2]} == 24'hFFD8FF) begin
				r.file_kind = KIND_JPEG;
			end else if (taken >= 4 && {head[0], head[1], head[2], head[3]} == "GIF8") begin
				r.file_kind = KIND_GIF;
			end else if (taken >= 2 && {head[0], head[1]} == 16'h1F8B) begin
				r.file_kind = KIND_GZIP;
			end else if (taken >= 4 && {head[0], head[1]} == "PK" &&
					({head[2], head[3]} == 16'h0304 || {head[2], head[3]} == 16'h0506)) begin
				r.file_kind = KIND_ZIP;
			end else if (taken >= 5 &&
					{head[0], head[1], head[2], head[3], head[4]} == "%PDF-") begin
				r.file_kind = KIND_PDF;
			end else if (taken >= TAR_END && tar_ok) begin
				r.file_kind = KIND_TAR;
			end else if (taken >= 2 && {head[0], head[1]} == "BM") begin
				r.file_kind = KIND_BMP;
			end else if (taken >= 12 && {head[0], head[1], head[2], head[3]} == "RIFF" &&
					{head[8], head[9], head[10], head[11]} == "WAVE") begin
				r.file_kind = KIND_WAV;
			end else if (taken >= 3 && {head[0], head[1], head[2]} == 24'hEFBBBF) begin
				r.file_kind = KIND_TEXT;
			end else if (clean) begin
				r.file_kind = KIND_TEXT;
			end
			verdicts_due.push_back(r);
			start_file();
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("time %0t: %s differs, expected %0d actual %0d", $time, field, want, got);
				failures++;
			end
		endfunction

		// Checks one accepted result word against the oldest verdict owed.
		function void check_result(logic [OUT_W-1:0] w);
			result_t e;
			if (verdicts_due.size() == 0) begin
				$display("time %0t: result word %h arrived with no verdict owed, expected none actual %h",
					$time, w, w);
				failures++;
				return;
			end
			e = verdicts_due.pop_front();
			compare("file_kind", e.file_kind, w[3:0]);
			compare("elf_kind", e.elf_kind, w[5:4]);
			compare("elf_arm", e.elf_arm, w[6]);
			compare("script_len", e.script_len, w[12:7]);
			compare("bytes_seen", e.bytes_seen, w[22:13]);
			compare("padding", 16'd0, w[23]);
		endfunction
	endclass

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;     // [7:0] data_byte
	logic             s_tlast  = 1'b0;   // end_of_file
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;           // [3:0] file_kind, [5:4] elf_kind, [6] elf_arm,
	                                     // [12:7] script_len, [22:13] bytes_seen, [23] zero

	verdict_board     board;
	logic [7:0]       file_bytes[$];
	int               tx_idle_pct = 0;
	int               rx_idle_pct = 0;
	bit               hold_req    = 1'b0;
	int               hold_left   = 0;
	int               cycles      = 0;

	file_magic_classifier #(
		.MAX_HEADER   (MAX_HEADER),
		.SCRIPT_LIMIT (SCRIPT_LIMIT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("file_magic_classifier: mismatch");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off on request so that the
	// result register stays full and end-of-file words back up the input.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Result words are sampled at the rising edge, before any register updates.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
	end

	// Filler bytes; the text-safe kind mixes in the permitted control bytes and high bytes, the line kind newlines.
	function automatic logic [7:0] filler(fill_t fm);
		int pick;
		pick = $urandom_range(0, 99);
		case (fm)
			FILL_ANY: return 8'($urandom_range(0, 255));
			FILL_PRINT: return 8'($urandom_range(32, 126));
			FILL_LINE: begin
				if (pick < 10) return 8'h0A;
				return 8'($urandom_range(32, 126));
			end
			default: begin
				if (pick < 8) begin
					case ($urandom_range(0, 4))
						0: return 8'd9;
						1: return 8'd10;
						2: return 8'd12;
						3: return 8'd13;
						default: return 8'd27;
					endcase
				end
				if (pick < 20) return 8'($urandom_range(128, 255));
				return 8'($urandom_range(32, 126));
			end
		endcase
	endfunction

	// Appends the lowest n bytes of v, most significant first.
	task automatic push_seq(input logic [63:0] v, input int n);
		int k;
		for (k = n - 1; k >= 0; k--) file_bytes.push_back(v[8 * k +: 8]);
	endtask

	// Builds a file of the given shape: its magic bytes, then filler.
	task automatic build_file(input shape_t sh, input int extra, input fill_t fm, input bit alt);
		file_bytes.delete();
		case (sh)
			SH_ELF:    push_seq(32'h7F454C46, 4);
			SH_SCRIPT: push_seq("#!", 2);
			SH_PNG:    push_seq(64'h89504E470D0A1A0A, 8);
			SH_JPEG:   push_seq(24'hFFD8FF, 3);
			SH_GIF:    push_seq("GIF8", 4);
			SH_GZIP:   push_seq(16'h1F8B, 2);
			SH_ZIP:    push_seq(alt ? 32'h504B0506 : 32'h504B0304, 4);
			SH_PDF:    push_seq("%PDF-", 5);
			SH_TAR: begin
				repeat (TAR_OFFSET) file_bytes.push_back(filler(fm));
				push_seq(USTAR, 5);
			end
			SH_BMP:    push_seq("BM", 2);
			SH_WAV: begin
				push_seq("RIFF", 4);
				repeat (4) file_bytes.push_back(filler(FILL_ANY));
				push_seq("WAVE", 4);
			end
			SH_BOM:    push_seq(24'hEFBBBF, 3);
			default: ;
		endcase
		if (sh != SH_EMPTY) repeat (extra) file_bytes.push_back(filler(fm));
	endtask

	// Writes the ELF type and machine fields, as far as the file reaches.
	task automatic set_elf_fields(input logic [15:0] et, input logic [15:0] mc);
		logic [31:0] f;
		int          k;
		f = {mc, et};
		for (k = 16; k < 20; k++) begin
			if (k < file_bytes.size()) file_bytes[k] = f[8 * (k - 16) +: 8];
		end
	endtask

	// Offers one word from the falling edge and holds it until it is taken.
	// Before each word the sender idles cycle by cycle at the set percentage.
	task automatic send_word(input logic [7:0] c, input logic eof);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eof;
		do @(posedge clk); while (!s_tready);
		board.note_word(c, eof);
		@(negedge clk);
	endtask

	// The end-of-file word carries a random byte, which the block must ignore.
	task automatic send_file();
		foreach (file_bytes[k]) send_word(file_bytes[k], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Mostly well-formed short headers with random content, plus near misses:
	// a flipped bit in the magic bytes or a cut-short file.
	task automatic random_files(input int words);
		int          sent;
		int          extra;
		int          span;
		int          idx;
		int          cut;
		shape_t      sh;
		fill_t       fm;
		logic [15:0] et;
		logic [15:0] mc;
		sent = 0;
		while (sent < words) begin
			sh    = shape_t'($urandom_range(0, SH_PLAIN));
			fm    = fill_t'($urandom_range(0, FILL_LINE));
			extra = $urandom_range(0, 16);
			if (sh == SH_ELF) extra = $urandom_range(8, 24);
			// Tar files are long, so they are left to the directed files.
			if (sh == SH_TAR) sh = SH_PLAIN;
			build_file(sh, extra, fm, $urandom_range(0, 1));
			if (sh == SH_ELF) begin
				case ($urandom_range(0, 3))
					0: et = 16'd1;
					1: et = 16'd2;
					2: et = 16'd3;
					default: et = 16'($urandom_range(0, 65535));
				endcase
				mc = $urandom_range(0, 1) ? ELF_MACHINE_ARM : 16'($urandom_range(0, 65535));
				set_elf_fields(et, mc);
			end
			if (file_bytes.size() > 0 && $urandom_range(0, 99) < 15) begin
				span = (file_bytes.size() < 12) ? file_bytes.size() : 12;
				idx  = $urandom_range(0, span - 1);
				file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
			if ($urandom_range(0, 99) < 10) begin
				cut = $urandom_range(0, file_bytes.size());
				while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
			end
			sent += file_bytes.size() + 1;
			send_file();
		end
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed files, first phase of idling: sender idles rarely, receiver often.
		tx_idle_pct = 19;
		rx_idle_pct = 88;
		build_file(SH_EMPTY, 0, FILL_ANY, 1'b0);
		send_file();
		// ELF with and without the ARM machine, and with a type outside the three known.
		build_file(SH_ELF, 16, FILL_ANY, 1'b0);
		set_elf_fields(16'd1, ELF_MACHINE_ARM);
		send_file();
		build_file(SH_ELF, 16, FILL_ANY, 1'b0);
		set_elf_fields(16'd2, 16'd3);
		send_file();
		build_file(SH_ELF, 16, FILL_ANY, 1'b0);
		set_elf_fields(16'h0100, 16'h2800);
		send_file();
		// Short ELF: only the magic, then a header cut inside the type field.
		build_file(SH_ELF, 0, FILL_ANY, 1'b0);
		send_file();
		build_file(SH_ELF, 13, FILL_ANY, 1'b0);
		set_elf_fields(16'd2, ELF_MACHINE_ARM);
		send_file();
		// Scripts: bare shebang, newline inside, newline right after the
		// shebang, and newline just past the limit.
		build_file(SH_SCRIPT, 0, FILL_PRINT, 1'b0);
		send_file();
		build_file(SH_SCRIPT, 10, FILL_PRINT, 1'b0);
		file_bytes[10] = 8'h0A;
		send_file();
		build_file(SH_SCRIPT, 3, FILL_PRINT, 1'b0);
		file_bytes[2] = 8'h0A;
		send_file();
		build_file(SH_SCRIPT, 41, FILL_PRINT, 1'b0);
		file_bytes[SCRIPT_LIMIT] = 8'h0A;
		send_file();
		// A PNG signature, then one a byte short, then each of the remaining magics.
		build_file(SH_PNG, 3, FILL_ANY, 1'b0);
		send_file();
		build_file(SH_PNG, 0, FILL_ANY, 1'b0);
		file_bytes.delete(7);
		send_file();
		build_file(SH_JPEG, 1, FILL_ANY, 1'b0);
		send_file();
		build_file(SH_GIF, 1, FILL_PRINT, 1'b0);
		send_file();
		build_file(SH_GZIP, 1, FILL_ANY, 1'b0);
		send_file();
		build_file(SH_ZIP, 0, FILL_ANY, 1'b0);
		send_file();
		build_file(SH_ZIP, 0, FILL_ANY, 1'b1);
		send_file();
		build_file(SH_PDF, 1, FILL_TEXT, 1'b0);
		send_file();
		build_file(SH_BMP, 1, FILL_ANY, 1'b0);
		send_file();
		build_file(SH_WAV, 0, FILL_ANY, 1'b0);
		send_file();
		// A byte-order mark makes text even with a zero byte behind it.
		build_file(SH_BOM, 5, FILL_ANY, 1'b0);
		file_bytes[5] = 8'h00;
		send_file();
		build_file(SH_PLAIN, 10, FILL_TEXT, 1'b0);
		send_file();
		build_file(SH_PLAIN, 8, FILL_PRINT, 1'b0);
		file_bytes[4] = 8'h7F;
		send_file();
		// Tar at its shortest.
		build_file(SH_TAR, 0, FILL_ANY, 1'b0);
		send_file();
		// Past the header window with one tag byte wrong: the zero byte is
		// ignored, the count stops and the file reads as text.
		build_file(SH_TAR, 258, FILL_PRINT, 1'b0);
		file_bytes[TAR_END - 1] = "R";
		file_bytes[MAX_HEADER + 3] = 8'h00;
		send_file();

		random_files(PHASE_WORDS);
		tx_idle_pct = 88;
		rx_idle_pct = 19;
		random_files(PHASE_WORDS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_files(PHASE_WORDS);

		// Back-pressure: the receiver holds off while short files keep coming.
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		repeat (10) begin
			build_file(shape_t'($urandom_range(SH_EMPTY, SH_GZIP)), $urandom_range(0, 3),
				FILL_ANY, 1'b0);
			send_file();
		end
		s_tvalid <= 1'b0;

		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0) begin
			$display("file_magic_classifier: match");
		end else begin
			$display("file_magic_classifier: mismatch");
		end
		$finish;
	end

endmodule
